// File: design/motor_speed_pid_dual_mode_core_macros.svh
// assertion macros for the dual-mode motor speed pid core
`ifndef MOTOR_SPEED_PID_DUAL_MODE_CORE_MACROS_SVH
`define MOTOR_SPEED_PID_DUAL_MODE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MSPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define MSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/mspd_pkg.sv
// shared types and constants for the dual-mode motor speed pid core
package mspd_pkg;

	localparam int ERR_W   = 17;
	localparam int DRIVE_W = 16;
	localparam int GAIN_W  = 16;
	localparam int LIM_W   = 15;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 3;
	localparam int FRAC_W  = 8;

	localparam logic signed [GAIN_W-1:0] GAIN_P_RST   = 16'sd256;
	localparam logic signed [GAIN_W-1:0] GAIN_I_RST   = 16'sd0;
	localparam logic signed [GAIN_W-1:0] GAIN_D_RST   = 16'sd0;
	localparam logic [LIM_W-1:0]         OUT_LIM_RST  = 15'd7000;
	localparam logic [LIM_W-1:0]         DEADBAND_RST = 15'd40;
	localparam logic [LIM_W-1:0]         SEP_RST      = 15'd1500;
	localparam logic [LIM_W-1:0]         INT_LIM_RST  = 15'd4000;

	typedef enum logic {
		MODE_INCR = 1'b0,
		MODE_POS  = 1'b1
	} mode_t;

	typedef enum logic {
		KIND_COMPUTE = 1'b0,
		KIND_CLEAR   = 1'b1
	} kind_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_MODE     = 3'd0,
		REG_GAIN_P   = 3'd1,
		REG_GAIN_I   = 3'd2,
		REG_GAIN_D   = 3'd3,
		REG_OUT_LIM  = 3'd4,
		REG_DEADBAND = 3'd5,
		REG_SEP      = 3'd6,
		REG_INT_LIM  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                      kind;
		logic [1:0]                motor;
		logic signed [DRIVE_W-1:0] target_speed;
		logic signed [DRIVE_W-1:0] measured_speed;
	} req_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      limited;
	} rsp_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIM_W-1:0]         output_limit;
		logic [LIM_W-1:0]         error_deadband;
		logic [LIM_W-1:0]         separation_bound;
		logic [LIM_W-1:0]         integral_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]   last_error;
		logic signed [ERR_W-1:0]   older_error;
		logic signed [ERR_W-1:0]   error_sum;
		logic signed [DRIVE_W-1:0] acc_drive;
	} motor_state_t;

	typedef struct packed {
		logic         en;
		logic         all;
		motor_state_t next;
	} state_wr_t;

endpackage

// File: design/mspd_req_if.sv
// request channel interface: valid, ready and one request payload
interface mspd_req_if;
	logic           valid;
	logic           ready;
	mspd_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/mspd_rsp_if.sv
// result channel interface: valid, ready and one result payload
interface mspd_rsp_if;
	logic           valid;
	logic           ready;
	mspd_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/motor_speed_pid_dual_mode_core.sv
// top level of the dual-mode motor speed pid core
//
//  port     dir   handshake        moves
//  req      sink  valid / ready    kind, motor, target_speed, measured_speed
//  rsp      src   valid / ready    drive, limited
//  cfg_*    in    cfg_wr_en only   register index and data, no read-back
//
// one request per cycle sustained while rsp.ready stays high; each request passes through
// the input stage and then the result register before its result is presented
// the per-motor history read-modify-write is written back as a request leaves the input
// stage, so a request on the same motor right behind the previous one sees its update
// reset zeroes history and both valid flags and restores the register defaults
// a stalled result holds the input stage, and req.ready then follows rsp.ready
`include "motor_speed_pid_dual_mode_core_macros.svh"

module motor_speed_pid_dual_mode_core #(
	parameter int MOTORS = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mspd_pkg::CIDX_W-1:0] cfg_index,
	input  logic [mspd_pkg::CFG_W-1:0]  cfg_wdata,
	mspd_req_if.sink                    req,
	mspd_rsp_if.source                  rsp
);

	localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

	mspd_pkg::cfg_t         cfg;
	mspd_pkg::motor_state_t cur_st;
	mspd_pkg::state_wr_t    st_wr;
	mspd_pkg::rsp_t         rsp_d;

	// input stage
	logic                   valid_s1;
	mspd_pkg::req_t         req_s1;

	// result register
	logic                   rsp_valid_q;
	mspd_pkg::rsp_t         rsp_q;

	logic                   advance;
	logic                   motor_ok;
	logic                   motor_all;
	logic [IDX_W-1:0]       idx;

	// the input stage moves on when the result register is free or being drained
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// motor decode: index equal to the motor count means all motors on clear
	assign motor_ok  = {30'd0, req_s1.motor} < 32'(MOTORS);
	assign motor_all = {30'd0, req_s1.motor} == 32'(MOTORS);
	assign idx       = IDX_W'(req_s1.motor);

	mspd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mspd_state #(
		.MOTORS (MOTORS),
		.IDX_W  (IDX_W)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (idx),
		.wr_go  (advance),
		.wr     (st_wr),
		.rd     (cur_st)
	);

	mspd_calc u_calc (
		.req       (req_s1),
		.motor_ok  (motor_ok),
		.motor_all (motor_all),
		.cfg       (cfg),
		.cur       (cur_st),
		.rsp       (rsp_d),
		.wr        (st_wr)
	);

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// input stage payload, no reset needed
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	// an empty input stage always takes a request
	`MSPD_ASSERT_NOW(a_empty_ready, clk, arst_n, !valid_s1, req.ready, "input stage empty but not ready")
	// a blocked result keeps the waiting request in the input stage
	`MSPD_ASSERT_NEXT(a_stall_hold, clk, arst_n, valid_s1 && rsp_valid_q && !rsp.ready, valid_s1 && $stable(req_s1), "input stage lost under stall")
	// clear requests report a zero drive
	`MSPD_ASSERT_NEXT(a_clear_zero, clk, arst_n, advance && (req_s1.kind == mspd_pkg::KIND_CLEAR), rsp.valid && (rsp.data.drive == 16'sd0) && !rsp.data.limited, "clear result not zero")
	// compute on a motor that does not exist reports a zero drive
	`MSPD_ASSERT_NEXT(a_bad_motor_zero, clk, arst_n, advance && (req_s1.kind == mspd_pkg::KIND_COMPUTE) && !motor_ok, rsp.valid && (rsp.data.drive == 16'sd0) && !rsp.data.limited, "invalid motor result not zero")

endmodule

// File: design/mspd_cfg.sv
// configuration register file written through the plain write port
module mspd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mspd_pkg::CIDX_W-1:0] cfg_index,
	input  logic [mspd_pkg::CFG_W-1:0]  cfg_wdata,
	output mspd_pkg::cfg_t              cfg
);

	mspd_pkg::cfg_t     cfg_q;
	mspd_pkg::cfg_reg_t sel;

	assign sel = mspd_pkg::cfg_reg_t'(cfg_index);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode             <= mspd_pkg::MODE_INCR;
			cfg_q.gain_p           <= mspd_pkg::GAIN_P_RST;
			cfg_q.gain_i           <= mspd_pkg::GAIN_I_RST;
			cfg_q.gain_d           <= mspd_pkg::GAIN_D_RST;
			cfg_q.output_limit     <= mspd_pkg::OUT_LIM_RST;
			cfg_q.error_deadband   <= mspd_pkg::DEADBAND_RST;
			cfg_q.separation_bound <= mspd_pkg::SEP_RST;
			cfg_q.integral_limit   <= mspd_pkg::INT_LIM_RST;
		end else if (cfg_wr_en) begin
			unique case (sel)
				mspd_pkg::REG_MODE:     cfg_q.mode <= mspd_pkg::mode_t'(cfg_wdata[0]);
				mspd_pkg::REG_GAIN_P:   cfg_q.gain_p <= cfg_wdata;
				mspd_pkg::REG_GAIN_I:   cfg_q.gain_i <= cfg_wdata;
				mspd_pkg::REG_GAIN_D:   cfg_q.gain_d <= cfg_wdata;
				mspd_pkg::REG_OUT_LIM:  cfg_q.output_limit <= cfg_wdata[mspd_pkg::LIM_W-1:0];
				mspd_pkg::REG_DEADBAND: cfg_q.error_deadband <= cfg_wdata[mspd_pkg::LIM_W-1:0];
				mspd_pkg::REG_SEP:      cfg_q.separation_bound <= cfg_wdata[mspd_pkg::LIM_W-1:0];
				mspd_pkg::REG_INT_LIM:  cfg_q.integral_limit <= cfg_wdata[mspd_pkg::LIM_W-1:0];
				default:                cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

// File: design/mspd_state.sv
// per-motor controller history: error taps, integral and accumulated drive
module mspd_state #(
	parameter int MOTORS = 2,
	parameter int IDX_W  = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IDX_W-1:0]       idx,
	input  logic                   wr_go,
	input  mspd_pkg::state_wr_t    wr,
	output mspd_pkg::motor_state_t rd
);

	mspd_pkg::motor_state_t st_q [MOTORS];

	// out-of-range index only happens on requests that never use the value
	assign rd = (32'(idx) < 32'(MOTORS)) ? st_q[idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < MOTORS; m++) begin
				st_q[m] <= '0;
			end
		end else if (wr_go && wr.all) begin
			for (int m = 0; m < MOTORS; m++) begin
				st_q[m] <= '0;
			end
		end else if (wr_go && wr.en && (32'(idx) < 32'(MOTORS))) begin
			st_q[idx] <= wr.next;
		end
	end

endmodule

// File: design/mspd_calc.sv
// single-pass pid datapath: error, operand select, three gain products, round and clamp
module mspd_calc (
	input  mspd_pkg::req_t         req,
	input  logic                   motor_ok,
	input  logic                   motor_all,
	input  mspd_pkg::cfg_t         cfg,
	input  mspd_pkg::motor_state_t cur,
	output mspd_pkg::rsp_t         rsp,
	output mspd_pkg::state_wr_t    wr
);

	logic signed [16:0] err;
	logic signed [17:0] d_p;
	logic signed [18:0] d_d;
	logic signed [16:0] dead_s;
	logic signed [16:0] sep_s;
	logic signed [17:0] ilim_s;
	logic               in_band;
	logic               in_sep;
	logic signed [16:0] e_pos;
	logic signed [16:0] sum_base;
	logic signed [17:0] integ;
	logic signed [17:0] integ_c;
	logic signed [16:0] esum_new;
	logic signed [17:0] d_pos;
	logic signed [17:0] op_p;
	logic signed [16:0] op_i;
	logic signed [18:0] op_d;
	logic signed [33:0] prod_p;
	logic signed [32:0] prod_i;
	logic signed [34:0] prod_d;
	logic signed [36:0] acc_q88;
	logic signed [36:0] acc_rnd;
	logic signed [28:0] rnd;
	logic signed [29:0] acc_sum;
	logic signed [29:0] olim_s;
	logic signed [15:0] inc_drive;
	logic               inc_lim;
	logic signed [15:0] pos_drive;
	logic               pos_lim;
	logic               incr;
	logic               clear;

	assign incr  = (cfg.mode == mspd_pkg::MODE_INCR);
	assign clear = (req.kind == mspd_pkg::KIND_CLEAR);

	assign err = 17'(req.target_speed) - 17'(req.measured_speed);

	// incremental differences
	assign d_p = 18'(err) - 18'(cur.last_error);
	assign d_d = 19'(err) - (19'(cur.last_error) <<< 1) + 19'(cur.older_error);

	// positional dead band and separated integral
	assign dead_s  = $signed({2'b00, cfg.error_deadband});
	assign sep_s   = $signed({2'b00, cfg.separation_bound});
	assign ilim_s  = $signed({3'b000, cfg.integral_limit});
	assign in_band = (err >= -dead_s) && (err <= dead_s);
	assign e_pos   = in_band ? '0 : err;
	assign sum_base = in_band ? '0 : cur.error_sum;
	assign in_sep  = (e_pos > -sep_s) && (e_pos < sep_s);
	assign integ   = 18'(sum_base) + 18'(e_pos);

	always_comb begin
		if (integ > ilim_s) begin
			integ_c = ilim_s;
		end else if (integ < -ilim_s) begin
			integ_c = -ilim_s;
		end else begin
			integ_c = integ;
		end
	end

	assign esum_new = in_sep ? integ_c[16:0] : sum_base;
	assign d_pos    = 18'(e_pos) - 18'(cur.older_error);

	// one multiplier per gain, shared by both forms
	assign op_p = incr ? d_p : 18'(e_pos);
	assign op_i = incr ? err : esum_new;
	assign op_d = incr ? d_d : 19'(d_pos);

	assign prod_p  = 34'(cfg.gain_p) * 34'(op_p);
	assign prod_i  = 33'(cfg.gain_i) * 33'(op_i);
	assign prod_d  = 35'(cfg.gain_d) * 35'(op_d);
	assign acc_q88 = 37'(prod_p) + 37'(prod_i) + 37'(prod_d);

	// round half up: add half an lsb, floor shift
	assign acc_rnd = acc_q88 + 37'sd128;
	assign rnd     = acc_rnd[36:mspd_pkg::FRAC_W];

	assign acc_sum = 30'(cur.acc_drive) + 30'(rnd);
	assign olim_s  = $signed({15'd0, cfg.output_limit});

	always_comb begin
		if (acc_sum > olim_s) begin
			inc_drive = olim_s[15:0];
			inc_lim   = 1'b1;
		end else if (acc_sum < -olim_s) begin
			inc_drive = 16'(-olim_s);
			inc_lim   = 1'b1;
		end else begin
			inc_drive = acc_sum[15:0];
			inc_lim   = 1'b0;
		end
	end

	always_comb begin
		if (rnd > 29'sd32767) begin
			pos_drive = 16'sh7FFF;
			pos_lim   = 1'b1;
		end else if (rnd < -29'sd32768) begin
			pos_drive = 16'sh8000;
			pos_lim   = 1'b1;
		end else begin
			pos_drive = rnd[15:0];
			pos_lim   = 1'b0;
		end
	end

	always_comb begin
		rsp     = '0;
		wr.en   = 1'b0;
		wr.all  = 1'b0;
		wr.next = cur;
		if (clear) begin
			wr.en   = motor_ok;
			wr.all  = motor_all;
			wr.next = '0;
		end else if (motor_ok) begin
			wr.en = 1'b1;
			if (incr) begin
				rsp.drive            = inc_drive;
				rsp.limited          = inc_lim;
				wr.next.acc_drive    = inc_drive;
				wr.next.older_error  = cur.last_error;
				wr.next.last_error   = err;
			end else begin
				rsp.drive            = pos_drive;
				rsp.limited          = pos_lim;
				wr.next.error_sum    = esum_new;
				wr.next.older_error  = e_pos;
			end
		end
	end

endmodule
